// File: src/epcs_pkg.sv
// Shared constants, types and codes for the event peak cell spectrum block.
package epcs_pkg;

    localparam int GRID_CELLS    = 20;
    localparam int CELL_UM       = 10;
    localparam int SPECTRUM_BINS = 300;

    localparam int NCELLS     = GRID_CELLS * GRID_CELLS;
    localparam int SPAN_UM    = GRID_CELLS * CELL_UM;
    localparam int HALF_UM    = SPAN_UM / 2;
    localparam int SPEC_LEN   = SPECTRUM_BINS + 1;
    localparam int SPEC_DEPTH = 2 * SPEC_LEN;

    localparam int CELL_W      = $clog2(GRID_CELLS);
    localparam int GRID_AW     = $clog2(NCELLS);
    localparam int SPEC_AW     = $clog2(SPEC_DEPTH);
    localparam int SPEC_BIN_W  = $clog2(SPEC_LEN);
    localparam int POS_W       = 17;
    localparam int SPAN_W      = $clog2(SPAN_UM + 1);
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SPAN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] CELL_RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + CELL_UM - 1) / CELL_UM);

    localparam int EPOCH_W   = 8;
    localparam int CELL_DW   = 32;
    localparam int GRID_DW   = CELL_DW + EPOCH_W;
    localparam int SWEEP_LEN = (NCELLS > SPEC_DEPTH) ? NCELLS : SPEC_DEPTH;
    localparam int SWEEP_W   = $clog2(SWEEP_LEN);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [19:0] WIDTH_RESET = 20'd10000;
    localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_HIT  = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_N    = 2'd1;
    localparam logic [1:0] CLS_G    = 2'd2;

    localparam logic KIND_PEAK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_HASH = 8'h23;

    typedef enum logic [1:0] {
        OP_HIT,
        OP_READ,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              open;
        logic [1:0]        class_set;
        logic              dep;
        logic [CELL_W-1:0] qx;
        logic [CELL_W-1:0] qy;
        logic [23:0]       edep;
        logic              sel;
        logic [8:0]        bin;
    } queue_entry_t;

endpackage

// File: src/event_peak_cell_spectrum.sv
// Top level of the event peak cell spectrum block.
// Hits, spectrum reads and end-of-run requests enter through a classifier that
// tracks the open event and bins the hit position into a grid cell; a four-entry
// queue decouples it from the back end, which owns the grid and spectrum RAMs.
// A hit inside an open event passes through the back end as a cell read, then a
// write; a spectrum read is a RAM read, then the reply. Closing an event that
// reports a peak runs the 32-step serial divider that forms the spectrum bin,
// then the spectrum read-modify-write; closing without a report skips both.
// The grid is cleared per event by an 8-bit epoch tag; every 256 events the tag
// wraps and a sweep over all 400 grid cells runs. After reset a clearing pass
// of both RAMs runs before the first request is accepted.
module event_peak_cell_spectrum import epcs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [19:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [31:0]        event_id,
    input  logic [7:0]         particle_char,
    input  logic [7:0]         process_char,
    input  logic signed [15:0] x_um,
    input  logic signed [15:0] y_um,
    input  logic [23:0]        edep_ev,
    input  logic               spectrum_select,
    input  logic [8:0]         spectrum_bin,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [31:0]        peak_ev,
    output logic               peak_class,
    output logic [31:0]        bin_count
);

    logic         init_done;
    logic         q_full;
    logic         q_empty;
    logic         q_push;
    logic         q_pop;
    queue_entry_t q_entry;
    queue_entry_t q_head;

    epcs_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .event_id        (event_id),
        .particle_char   (particle_char),
        .process_char    (process_char),
        .x_um            (x_um),
        .y_um            (y_um),
        .edep_ev         (edep_ev),
        .spectrum_select (spectrum_select),
        .spectrum_bin    (spectrum_bin),
        .init_done       (init_done),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_entry)
    );

    epcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    epcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .init_done  (init_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .peak_ev    (peak_ev),
        .peak_class (peak_class),
        .bin_count  (bin_count)
    );

endmodule

// File: src/epcs_ram.sv
// Generic single write port RAM with one registered read port.
module epcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/epcs_queue.sv
// Short request queue between the classifier and the execution back end.
module epcs_queue import epcs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output queue_entry_t head,
    output logic         full,
    output logic         empty
);

    queue_entry_t          store_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/epcs_front.sv
// Front end: accepts requests, tracks the open event and classifies hits.
module epcs_front import epcs_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [31:0]         event_id,
    input  logic [7:0]          particle_char,
    input  logic [7:0]          process_char,
    input  logic signed [15:0]  x_um,
    input  logic signed [15:0]  y_um,
    input  logic [23:0]         edep_ev,
    input  logic                spectrum_select,
    input  logic [8:0]          spectrum_bin,
    input  logic                init_done,
    input  logic                q_full,
    output logic                q_push,
    output queue_entry_t        q_entry
);

    logic [31:0]       cur_event_reg;
    logic              seen_reg;
    logic              accept;
    logic              keep;
    logic [POS_W-1:0]  dx;
    logic [POS_W-1:0]  dy;
    logic              in_x;
    logic              in_y;
    logic [PROD_W-1:0] px;
    logic [PROD_W-1:0] py;
    logic              is_dep_particle;

    assign in_ready = init_done && !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        dx = {x_um[15], x_um} + POS_W'(HALF_UM);
        dy = {y_um[15], y_um} + POS_W'(HALF_UM);
        in_x = !dx[POS_W-1] && (dx[POS_W-2:0] < (POS_W-1)'(SPAN_UM));
        in_y = !dy[POS_W-1] && (dy[POS_W-2:0] < (POS_W-1)'(SPAN_UM));
        // divide by the cell size through a reciprocal; exact over the window
        px = PROD_W'(dx[SPAN_W-1:0]) * PROD_W'(CELL_RECIP);
        py = PROD_W'(dy[SPAN_W-1:0]) * PROD_W'(CELL_RECIP);
        is_dep_particle = (particle_char == CH_E) || (particle_char == CH_A)
                       || (particle_char == CH_L);

        q_entry.open = !seen_reg || (event_id != cur_event_reg);
        q_entry.class_set = CLS_NONE;
        if (process_char == CH_HASH)
        begin
            if (particle_char == CH_N)
            begin
                q_entry.class_set = CLS_N;
            end
            else if (particle_char == CH_G)
            begin
                q_entry.class_set = CLS_G;
            end
        end
        q_entry.dep  = is_dep_particle && in_x && in_y;
        q_entry.qx   = px[RECIP_SHIFT +: CELL_W];
        q_entry.qy   = py[RECIP_SHIFT +: CELL_W];
        q_entry.edep = edep_ev;
        q_entry.sel  = spectrum_select;
        q_entry.bin  = spectrum_bin;

        unique case (action)
            ACT_HIT:
            begin
                q_entry.op = OP_HIT;
                keep = 1'b1;
            end
            ACT_READ:
            begin
                q_entry.op = OP_READ;
                keep = 1'b1;
            end
            ACT_END:
            begin
                q_entry.op = OP_CLOSE;
                keep = seen_reg;
            end
            default:
            begin
                q_entry.op = OP_CLOSE;
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = accept && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_event_reg <= '0;
            seen_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (action == ACT_HIT)
            begin
                cur_event_reg <= event_id;
                seen_reg      <= 1'b1;
            end
            else if (action == ACT_END)
            begin
                seen_reg <= 1'b0;
            end
        end
    end

endmodule

// File: src/epcs_back.sv
// Back end: grid accumulation, event close, peak binning and spectrum access.
module epcs_back import epcs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [19:0]  cfg_wdata,
    input  logic         q_empty,
    input  queue_entry_t q_head,
    output logic         q_pop,
    output logic         init_done,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         kind,
    output logic [31:0]  peak_ev,
    output logic         peak_class,
    output logic [31:0]  bin_count
);

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DIV,
        ST_SPRD,
        ST_SPWR,
        ST_CLR,
        ST_POST,
        ST_GWR,
        ST_RREP
    } state_t;

    state_t               state_reg;
    queue_entry_t         cur_reg;
    logic [19:0]          width_reg;
    logic [EPOCH_W-1:0]   epoch_reg;
    logic [31:0]          peak_reg;
    logic [1:0]           class_reg;
    logic [SWEEP_W-1:0]   sweep_cnt_reg;
    logic                 sweep_spec_reg;
    logic                 resume_reg;
    logic                 init_done_reg;
    logic [4:0]           div_cnt_reg;
    logic [31:0]          div_num_reg;
    logic [19:0]          div_rem_reg;
    logic [31:0]          div_q_reg;
    logic [SPEC_AW-1:0]   spec_addr_reg;
    logic                 out_valid_reg;
    logic                 kind_reg;
    logic [31:0]          peak_ev_reg;
    logic                 peak_class_reg;
    logic [31:0]          bin_count_reg;

    logic                 g_we;
    logic [GRID_AW-1:0]   g_waddr;
    logic [GRID_DW-1:0]   g_wdata;
    logic                 g_re;
    logic [GRID_AW-1:0]   g_raddr;
    logic [GRID_DW-1:0]   g_rdata;
    logic                 s_we;
    logic [SPEC_AW-1:0]   s_waddr;
    logic [31:0]          s_wdata;
    logic                 s_re;
    logic [SPEC_AW-1:0]   s_raddr;
    logic [31:0]          s_rdata;

    logic                 out_free;
    logic                 out_load;
    logic                 close_hit;
    logic [GRID_AW-1:0]   head_cell;
    logic [GRID_AW-1:0]   cur_cell;
    logic [19:0]          div_w;
    logic [20:0]          rem_sh;
    logic [SPEC_BIN_W-1:0] peak_bin;
    logic [SPEC_AW-1:0]   peak_addr;
    logic [SPEC_AW-1:0]   read_addr;
    logic                 read_ok;
    logic [31:0]          old_cell;
    logic [32:0]          sum_wide;
    logic [31:0]          cell_sum;
    logic [SWEEP_W-1:0]   sweep_last;
    logic [EPOCH_W-1:0]   epoch_inc;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = ((state_reg == ST_SPWR) || (state_reg == ST_RREP)) && out_free;
    assign close_hit = (peak_reg != '0) && ((class_reg == CLS_N) || (class_reg == CLS_G));
    assign head_cell = GRID_AW'(q_head.qx) * GRID_AW'(GRID_CELLS) + GRID_AW'(q_head.qy);
    assign cur_cell  = GRID_AW'(cur_reg.qx) * GRID_AW'(GRID_CELLS) + GRID_AW'(cur_reg.qy);
    assign div_w     = (width_reg == '0) ? 20'd1 : width_reg;
    assign rem_sh    = {div_rem_reg, div_num_reg[31]};
    assign peak_bin  = (div_q_reg > 32'(SPECTRUM_BINS))
                     ? SPEC_BIN_W'(SPECTRUM_BINS) : div_q_reg[SPEC_BIN_W-1:0];
    assign peak_addr = (class_reg == CLS_G)
                     ? SPEC_AW'(SPEC_LEN) + SPEC_AW'(peak_bin) : SPEC_AW'(peak_bin);
    assign read_ok   = (q_head.bin <= 9'(SPECTRUM_BINS));
    assign read_addr = q_head.sel
                     ? SPEC_AW'(SPEC_LEN) + SPEC_AW'(q_head.bin) : SPEC_AW'(q_head.bin);
    // a cell whose tag is from an earlier event reads as empty
    assign old_cell  = (g_rdata[GRID_DW-1 -: EPOCH_W] == epoch_reg)
                     ? g_rdata[CELL_DW-1:0] : '0;
    assign sum_wide  = {1'b0, old_cell} + 33'(cur_reg.edep);
    assign cell_sum  = sum_wide[32] ? SAT32 : sum_wide[31:0];
    assign sweep_last = sweep_spec_reg ? SWEEP_W'(SWEEP_LEN - 1) : SWEEP_W'(NCELLS - 1);
    assign epoch_inc = epoch_reg + 1'b1;

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = cur_cell;
        g_wdata = {epoch_reg, cell_sum};
        g_re    = 1'b0;
        g_raddr = cur_cell;
        s_we    = 1'b0;
        s_waddr = spec_addr_reg;
        s_wdata = (s_rdata == SAT32) ? SAT32 : s_rdata + 32'd1;
        s_re    = 1'b0;
        s_raddr = peak_addr;
        unique case (state_reg)
            ST_SWEEP:
            begin
                g_we    = (sweep_cnt_reg < SWEEP_W'(NCELLS));
                g_waddr = sweep_cnt_reg[GRID_AW-1:0];
                g_wdata = {epoch_reg, {CELL_DW{1'b0}}};
                s_we    = sweep_spec_reg && (sweep_cnt_reg < SWEEP_W'(SPEC_DEPTH));
                s_waddr = sweep_cnt_reg[SPEC_AW-1:0];
                s_wdata = '0;
            end
            ST_IDLE:
            begin
                g_raddr = head_cell;
                g_re    = !q_empty && (q_head.op == OP_HIT) && !q_head.open && q_head.dep;
                s_raddr = read_addr;
                s_re    = !q_empty && (q_head.op == OP_READ) && read_ok;
            end
            ST_SPRD:
            begin
                s_re = 1'b1;
            end
            ST_SPWR:
            begin
                s_we = out_free;
            end
            ST_POST:
            begin
                g_re = (cur_reg.op == OP_HIT) && cur_reg.dep;
            end
            ST_GWR:
            begin
                g_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            width_reg      <= WIDTH_RESET;
            epoch_reg      <= '0;
            peak_reg       <= '0;
            class_reg      <= CLS_NONE;
            sweep_cnt_reg  <= '0;
            sweep_spec_reg <= 1'b1;
            resume_reg     <= 1'b0;
            init_done_reg  <= 1'b0;
            div_cnt_reg    <= '0;
            div_num_reg    <= '0;
            div_rem_reg    <= '0;
            div_q_reg      <= '0;
            spec_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_PEAK;
            peak_ev_reg    <= '0;
            peak_class_reg <= 1'b0;
            bin_count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_SWEEP:
                begin
                    if (sweep_cnt_reg == sweep_last)
                    begin
                        sweep_cnt_reg  <= '0;
                        sweep_spec_reg <= 1'b0;
                        init_done_reg  <= 1'b1;
                        resume_reg     <= 1'b0;
                        state_reg      <= resume_reg ? ST_POST : ST_IDLE;
                    end
                    else
                    begin
                        sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        unique case (q_head.op)
                            OP_READ:
                            begin
                                state_reg <= ST_RREP;
                            end
                            OP_HIT:
                            begin
                                if (q_head.open)
                                begin
                                    state_reg <= close_hit ? ST_DIV : ST_CLR;
                                end
                                else if (q_head.dep)
                                begin
                                    state_reg <= ST_GWR;
                                end
                            end
                            OP_CLOSE:
                            begin
                                state_reg <= close_hit ? ST_DIV : ST_CLR;
                            end
                            default:
                            begin
                            end
                        endcase
                        div_num_reg <= peak_reg;
                        div_rem_reg <= '0;
                        div_q_reg   <= '0;
                        div_cnt_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    // one quotient bit per cycle, restoring
                    if (rem_sh >= {1'b0, div_w})
                    begin
                        div_rem_reg <= 20'(rem_sh - {1'b0, div_w});
                        div_q_reg   <= {div_q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        div_rem_reg <= rem_sh[19:0];
                        div_q_reg   <= {div_q_reg[30:0], 1'b0};
                    end
                    div_num_reg <= {div_num_reg[30:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_SPRD;
                    end
                end
                ST_SPRD:
                begin
                    spec_addr_reg <= peak_addr;
                    state_reg     <= ST_SPWR;
                end
                ST_SPWR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        kind_reg       <= KIND_PEAK;
                        peak_ev_reg    <= peak_reg;
                        peak_class_reg <= (class_reg == CLS_G);
                        bin_count_reg  <= '0;
                        class_reg      <= CLS_NONE;
                        state_reg      <= ST_CLR;
                    end
                end
                ST_CLR:
                begin
                    // advance the epoch to clear the grid; sweep it when the tag wraps
                    epoch_reg <= epoch_inc;
                    peak_reg  <= '0;
                    if ((cur_reg.op == OP_HIT) && (cur_reg.class_set != CLS_NONE))
                    begin
                        class_reg <= cur_reg.class_set;
                    end
                    if (epoch_inc == '0)
                    begin
                        sweep_cnt_reg <= '0;
                        resume_reg    <= 1'b1;
                        state_reg     <= ST_SWEEP;
                    end
                    else
                    begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST:
                begin
                    state_reg <= ((cur_reg.op == OP_HIT) && cur_reg.dep) ? ST_GWR : ST_IDLE;
                end
                ST_GWR:
                begin
                    if (cell_sum > peak_reg)
                    begin
                        peak_reg <= cell_sum;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_RREP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        kind_reg       <= KIND_READ;
                        peak_ev_reg    <= '0;
                        peak_class_reg <= 1'b0;
                        bin_count_reg  <= (cur_reg.bin <= 9'(SPECTRUM_BINS)) ? s_rdata : '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign init_done  = init_done_reg;
    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign peak_ev    = peak_ev_reg;
    assign peak_class = peak_class_reg;
    assign bin_count  = bin_count_reg;

    epcs_ram #(
        .WIDTH (GRID_DW),
        .DEPTH (NCELLS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    epcs_ram #(
        .WIDTH (32),
        .DEPTH (SPEC_DEPTH)
    ) u_spec_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

endmodule

// File: verif/tb_event_peak_cell_spectrum.sv
// Testbench for the event peak cell spectrum block: directed and random requests.
`timescale 1ns / 1ps

module tb_event_peak_cell_spectrum;
    import epcs_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] peak_ev;
        logic        peak_class;
        logic [31:0] bin_count;
    } peak_reply_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [19:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic [31:0]        event_id;
    logic [7:0]         particle_char;
    logic [7:0]         process_char;
    logic signed [15:0] x_um;
    logic signed [15:0] y_um;
    logic [23:0]        edep_ev;
    logic               spectrum_select;
    logic [8:0]         spectrum_bin;
    logic               out_valid;
    logic               out_ready;
    logic               kind;
    logic [31:0]        peak_ev;
    logic               peak_class;
    logic [31:0]        bin_count;

    // predictor state
    logic [31:0] cell_sum [NCELLS];
    logic [31:0] spec_count [SPEC_DEPTH];
    logic [31:0] peak_now;
    logic [31:0] open_event;
    logic        event_open;
    logic [1:0]  open_class;
    logic [19:0] bin_width;

    peak_reply_t pending_replies [$];
    int          errors;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [31:0] next_event;

    event_peak_cell_spectrum uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .event_id(event_id), .particle_char(particle_char),
        .process_char(process_char), .x_um(x_um), .y_um(y_um),
        .edep_ev(edep_ev), .spectrum_select(spectrum_select),
        .spectrum_bin(spectrum_bin), .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .peak_ev(peak_ev), .peak_class(peak_class),
        .bin_count(bin_count)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void clear_grid();
        for (int i = 0; i < NCELLS; i++)
            cell_sum[i] = '0;
        peak_now = '0;
    endfunction

    function automatic void close_open_event();
        logic [31:0] w;
        logic [31:0] b;
        int          idx;
        peak_reply_t r;
        if (event_open && peak_now != 0 && (open_class == CLS_N || open_class == CLS_G))
        begin
            w = (bin_width == 0) ? 32'd1 : {12'd0, bin_width};
            b = peak_now / w;
            if (b > SPECTRUM_BINS)
                b = SPECTRUM_BINS;
            idx = (open_class == CLS_G ? SPEC_LEN : 0) + int'(b);
            if (spec_count[idx] != SAT32)
                spec_count[idx] = spec_count[idx] + 1;
            r.kind = KIND_PEAK;
            r.peak_ev = peak_now;
            r.peak_class = (open_class == CLS_G);
            r.bin_count = '0;
            pending_replies.push_back(r);
            open_class = CLS_NONE;
        end
        clear_grid();
    endfunction

    function automatic void predict_request(logic [1:0] act, logic [31:0] ev,
                                            logic [7:0] pc, logic [7:0] pr,
                                            logic signed [15:0] x,
                                            logic signed [15:0] y,
                                            logic [23:0] e, logic sel,
                                            logic [8:0] bin);
        int          dx;
        int          dy;
        int          idx;
        logic [32:0] sum;
        peak_reply_t r;
        if (act == ACT_HIT)
        begin
            if (!event_open || ev != open_event)
            begin
                close_open_event();
                open_event = ev;
                event_open = 1'b1;
                if (pr == CH_HASH)
                begin
                    if (pc == CH_N)
                        open_class = CLS_N;
                    else if (pc == CH_G)
                        open_class = CLS_G;
                end
            end
            dx = int'(x) + HALF_UM;
            dy = int'(y) + HALF_UM;
            if ((pc == CH_E || pc == CH_A || pc == CH_L) &&
                dx >= 0 && dx < SPAN_UM && dy >= 0 && dy < SPAN_UM)
            begin
                idx = (dx / CELL_UM) * GRID_CELLS + dy / CELL_UM;
                sum = {1'b0, cell_sum[idx]} + {9'd0, e};
                cell_sum[idx] = sum[32] ? SAT32 : sum[31:0];
                if (cell_sum[idx] > peak_now)
                    peak_now = cell_sum[idx];
            end
        end
        else if (act == ACT_READ)
        begin
            r.kind = KIND_READ;
            r.peak_ev = '0;
            r.peak_class = 1'b0;
            r.bin_count = (bin <= SPECTRUM_BINS) ?
                          spec_count[(sel ? SPEC_LEN : 0) + int'(bin)] : '0;
            pending_replies.push_back(r);
        end
        else if (act == ACT_END)
        begin
            if (event_open)
            begin
                close_open_event();
                event_open = 1'b0;
            end
        end
    endfunction

    // check results against the expected queue
    always @(posedge clk)
    begin
        peak_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d peak=%0d class=%0d count=%0d",
                         $time, kind, peak_ev, peak_class, bin_count);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (want.kind !== kind || want.peak_ev !== peak_ev ||
                    want.peak_class !== peak_class || want.bin_count !== bin_count)
                begin
                    $display("%0t: mismatch expected kind=%0d peak=%0d class=%0d count=%0d",
                             $time, want.kind, want.peak_ev, want.peak_class,
                             want.bin_count);
                    $display("%0t:           actual kind=%0d peak=%0d class=%0d count=%0d",
                             $time, kind, peak_ev, peak_class, bin_count);
                    errors++;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid is dropped by the next idle cycle or by drain, never twice in one step
    task automatic send_request(logic [1:0] act, logic [31:0] ev, logic [7:0] pc,
                                logic [7:0] pr, logic signed [15:0] x,
                                logic signed [15:0] y, logic [23:0] e,
                                logic sel, logic [8:0] bin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        event_id <= ev;
        particle_char <= pc;
        process_char <= pr;
        x_um <= x;
        y_um <= y;
        edep_ev <= e;
        spectrum_select <= sel;
        spectrum_bin <= bin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(act, ev, pc, pr, x, y, e, sel, bin);
    endtask

    task automatic send_hit(logic [31:0] ev, logic [7:0] pc, logic [7:0] pr,
                            logic signed [15:0] x, logic signed [15:0] y,
                            logic [23:0] e);
        send_request(ACT_HIT, ev, pc, pr, x, y, e, $urandom_range(1),
                     $urandom_range(511));
    endtask

    task automatic send_read(logic sel, logic [8:0] bin);
        send_request(ACT_READ, $urandom, $urandom_range(255), $urandom_range(255),
                     $urandom, $urandom, $urandom, sel, bin);
    endtask

    task automatic send_end();
        send_request(ACT_END, $urandom, $urandom_range(255), $urandom_range(255),
                     $urandom, $urandom, $urandom, $urandom_range(1),
                     $urandom_range(511));
    endtask

    // wait for all results, then let the back end settle before a register write
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (500)
            @(posedge clk);
    endtask

    task automatic write_bin_width(logic [19:0] w);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        bin_width = w;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        send_read(1'b0, 9'd0);
        send_end();
        // two events, neutron then gamma, with corner cells and saturation
        send_hit(32'd5, CH_N, CH_HASH, -16'sd100, -16'sd100, 24'd12345);
        send_hit(32'd5, CH_E, 8'h68, -16'sd100, -16'sd100, 24'hFFFFFF);
        send_hit(32'd5, CH_A, 8'h68, 16'sd99, 16'sd99, 24'd7);
        send_hit(32'd5, CH_L, 8'h68, 16'sd100, 16'sd0, 24'd99);
        send_hit(32'd5, CH_E, 8'h68, -16'sd101, 16'sd0, 24'd99);
        send_hit(32'd5, CH_E, 8'h68, 16'sh7FFF, -16'sh8000, 24'd99);
        send_hit(32'hFFFFFFFF, CH_G, CH_HASH, 16'sd0, 16'sd0, 24'd0);
        send_hit(32'hFFFFFFFF, CH_E, 8'h68, 16'sd0, 16'sd0, 24'd25000);
        send_hit(32'hFFFFFFFF, CH_G, 8'h68, 16'sd0, 16'sd0, 24'd25000);
        // event with no class: carry over empty peaks, then a huge one
        send_hit(32'd0, CH_E, 8'h68, 16'sd5, 16'sd5, 24'd3);
        send_hit(32'd1, 8'h78, CH_HASH, 16'sd5, 16'sd5, 24'd3);
        send_hit(32'd2, CH_N, CH_HASH, 16'sd5, 16'sd5, 24'd3);
        send_hit(32'd3, CH_E, 8'h00, 16'sd5, 16'sd5, 24'hFFFFFF);
        send_end();
        send_end();
        send_read(1'b0, 9'd0);
        send_read(1'b0, 9'd300);
        send_read(1'b1, 9'd2);
        send_read(1'b1, 9'd301);
        send_read(1'b1, 9'd511);
        send_request(2'd3, 32'd9, CH_E, 8'h68, 16'sd0, 16'sd0, 24'd5, 1'b0, 9'd0);
        drain();
    endtask

    task automatic random_event();
        logic [31:0] ev;
        int          hits;
        logic [7:0]  cls_char;
        int          r;
        ev = ($urandom_range(9) == 0) ? $urandom : next_event;
        next_event = next_event + 1;
        hits = $urandom_range(1, 5);
        cls_char = $urandom_range(1) ? CH_N : CH_G;
        for (int h = 0; h < hits; h++)
        begin
            r = $urandom_range(99);
            if (h == 0 && r < 80)
                send_hit(ev, cls_char, CH_HASH, $urandom_range(240) - 120,
                         $urandom_range(240) - 120, $urandom_range(50000));
            else if (r < 75)
                send_hit(ev, (r % 3 == 0) ? CH_E : (r % 3 == 1) ? CH_A : CH_L,
                         $urandom_range(255), $urandom_range(240) - 120,
                         $urandom_range(240) - 120,
                         (r < 5) ? $urandom : $urandom_range(1500000));
            else if (r < 90)
                send_hit(ev, $urandom_range(255), $urandom_range(255),
                         $urandom, $urandom, $urandom);
            else if (r < 95)
                send_read($urandom_range(1), $urandom_range(304));
            else
                send_end();
        end
        if ($urandom_range(7) == 0)
            send_end();
    endtask

    task automatic test_random(int n_events);
        for (int i = 0; i < n_events; i++)
        begin
            random_event();
            if ($urandom_range(3) == 0)
                send_read($urandom_range(1), $urandom_range(511));
        end
    endtask

    initial
    begin
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        next_event = 32'd100;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        action = ACT_HIT;
        event_id = '0;
        particle_char = '0;
        process_char = '0;
        x_um = '0;
        y_um = '0;
        edep_ev = '0;
        spectrum_select = 1'b0;
        spectrum_bin = '0;
        for (int i = 0; i < SPEC_DEPTH; i++)
            spec_count[i] = '0;
        clear_grid();
        open_event = '0;
        event_open = 1'b0;
        open_class = CLS_NONE;
        bin_width = WIDTH_RESET;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_bin_width(20'd0);
        test_random(60);
        write_bin_width(20'hFFFFF);
        send_idle_pct = 88;
        test_random(40);
        write_bin_width(20'd1);
        send_idle_pct = 0;
        recv_stall_pct = 88;
        test_random(40);
        write_bin_width(20'd1000);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        test_random(60);
        write_bin_width(20'd1000000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(60);
        for (int b = 0; b < 8; b++)
            send_read(b[0], $urandom_range(301));
        send_end();

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
